// ----- hw/rtl/nig_posterior_update_core_assert.svh -----
// assertion macros for the posterior update core
`ifndef NIG_POSTERIOR_UPDATE_CORE_ASSERT_SVH
`define NIG_POSTERIOR_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NIG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nig assertion failed");
// next-cycle implication
`define NIG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nig assertion failed");
`else
`define NIG_ASSERT_IMP(label, clk, rstn, ante, cons)
`define NIG_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/nig_pkg.sv -----
package nig_pkg;

    localparam int NUM_W   = 128;
    localparam int DEN_W   = 64;
    localparam int STEP_W  = 8;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR_KAPPA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR_ALPHA = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR_BETA  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 8'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQUARE,
        S_MUL,
        S_BETA,
        S_SUM,
        S_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_MEAN,
        OP_BETA,
        OP_ALEA,
        OP_EPI1,
        OP_EPI2,
        OP_INV,
        OP_EMEAN,
        OP_AMEAN
    } div_op_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_quo(input logic [NUM_W-1:0] q);
        return (|q[NUM_W-1:64]) ? '1 : q[63:0];
    endfunction

endpackage

// ----- hw/rtl/nig_ram.sv -----
module nig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/nig_div.sv -----
module nig_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nig_pkg::div_ctl_t               ctl,
    input  logic [nig_pkg::NUM_W-1:0]       num,
    input  logic [nig_pkg::DEN_W-1:0]       den,
    output nig_pkg::div_stat_t              stat,
    output logic [nig_pkg::NUM_W-1:0]       quo
);
    import nig_pkg::*;

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;

    // one restoring step: numerator arrives left aligned, msb first
    always_comb begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
        diff   = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= ctl.steps;
            end else if (cnt_reg != '0) begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quo       = quo_reg;
endmodule

// ----- hw/rtl/nig_posterior_update_core.sv -----
// channel   ports                                    direction
// s_        s_valid s_ready s_obs_value              observation element in
// m_        m_valid m_ready m_dim_index .. m_*_mean  posterior result out
// cfg_      cfg_valid cfg_ready cfg_index cfg_data   register write in
//
// each element runs through the shared radix-2 divider (one quotient bit per cycle), six
// divisions per element; three when alpha + (vectors seen + 1) / 2 is not above one, and
// the last element of a vector adds two more divisions for the means
// after reset a clearing pass zeroes both stores; s_ready low
// s_ready is high only while the sequencer is idle; a result waits in the output
// register, and the next element finishes only once that word is taken
`include "nig_posterior_update_core_assert.svh"

module nig_posterior_update_core #(
    parameter int MAX_DIMS   = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_obs_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [5:0]                        m_dim_index,
    output logic signed [31:0]                m_post_mean,
    output logic [63:0]                       m_inv_variance,
    output logic [63:0]                       m_epistemic_var,
    output logic [63:0]                       m_aleatoric_var,
    output logic                              m_vector_done,
    output logic [63:0]                       m_epistemic_mean,
    output logic [63:0]                       m_aleatoric_mean,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nig_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import nig_pkg::*;

    localparam int PW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // configuration
    logic [31:0] kappa_reg, alpha_reg, beta0_reg;
    logic [6:0]  dims_reg;

    // sequencer and stream state
    state_t          state_reg, state_next;
    div_op_t         op_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   clr_reg;
    logic [COUNT_BITS-1:0] vcount_reg;
    logic [63:0]     esum_reg, asum_reg;
    logic            last_reg;
    logic [2:0]      mc_reg;

    // per element datapath
    logic signed [31:0] y_reg, mu0_reg, mean_new_reg;
    logic [31:0]     mag_reg;
    logic            neg_reg;
    logic [63:0]     ex_reg, ex_new_reg, beta_reg;
    logic [63:0]     k0_reg, kn_reg, am1_reg;
    logic [63:0]     sq_reg, pp_reg;
    logic [1:0]      pp_sh_reg;
    logic [NUM_W-1:0] acc_reg, epi_q_reg;
    logic [63:0]     alea_reg, epi_reg, inv_reg, emean_reg, amean_reg;

    // output register
    logic            out_valid_reg;
    logic [5:0]      o_dim_reg;
    logic signed [31:0] o_mean_reg;
    logic [63:0]     o_inv_reg, o_epi_reg, o_alea_reg, o_emean_reg, o_amean_reg;
    logic            o_done_reg;

    // wires
    logic [6:0]      d_eff;
    logic            last_now;
    logic            in_fire, commit_fire;
    logic [31:0]     mu_rd;
    logic [63:0]     ex_rd;
    logic            ram_we;
    logic [PW-1:0]   ram_waddr;
    logic [31:0]     mean_wdata;
    logic [63:0]     ex_wdata;
    div_ctl_t        div_ctl;
    div_stat_t       div_stat;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic [31:0]     mul_a, mul_b;
    logic [63:0]     mul_p;
    logic [32:0]     delta;
    logic [33:0]     mean_sum;
    logic [64:0]     am1_sum;
    logic [63:0]     epi_floor;

    // effective dimension count and last flag
    always_comb begin
        if (dims_reg == '0) begin
            d_eff = 7'd1;
        end else if ({25'b0, dims_reg} > MAX_DIMS) begin
            d_eff = 7'(MAX_DIMS);
        end else begin
            d_eff = dims_reg;
        end
        last_now = (32'(pos_reg) + 32'd1) >= {25'b0, d_eff};
    end

    assign in_fire     = s_valid && s_ready;
    assign commit_fire = (state_reg == S_COMMIT) && (!out_valid_reg || m_ready);
    assign cfg_ready   = 1'b1;

    // config register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kappa_reg <= 32'd65536;
            alpha_reg <= 32'd131072;
            beta0_reg <= 32'd65536;
            dims_reg  <= 7'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PRIOR_KAPPA: kappa_reg <= cfg_data;
                REG_PRIOR_ALPHA: alpha_reg <= cfg_data;
                REG_PRIOR_BETA:  beta0_reg <= cfg_data;
                REG_DIMS_IN_USE: dims_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // posterior stores
    nig_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_mean_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mean_wdata),
        .raddr (pos_reg),
        .rdata (mu_rd)
    );

    nig_ram #(.WIDTH(64), .DEPTH(MAX_DIMS)) u_excess_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ex_wdata),
        .raddr (pos_reg),
        .rdata (ex_rd)
    );

    // shared divider
    nig_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = mag_reg;
        mul_b = mag_reg;
        if (state_reg == S_MUL) begin
            mul_a = mc_reg[0] ? sq_reg[63:32] : sq_reg[31:0];
            mul_b = mc_reg[1] ? k0_reg[63:32] : k0_reg[31:0];
        end
    end
    assign mul_p = mul_a * mul_b;

    // divider control and operand select, numerators left aligned
    always_comb begin
        div_ctl.start = (state_reg == S_DIV_START);
        epi_floor = (epi_reg < 64'd4) ? 64'd4 : epi_reg;
        case (op_reg)
            OP_MEAN: begin
                div_num = {mag_reg, 16'b0, 80'b0};
                div_den = kn_reg;
                div_ctl.steps = 8'd48;
            end
            OP_BETA: begin
                div_num = acc_reg;
                div_den = {kn_reg[62:0], 1'b0};
                div_ctl.steps = 8'd128;
            end
            OP_ALEA: begin
                div_num = {beta_reg, 16'b0, 48'b0};
                div_den = am1_reg;
                div_ctl.steps = 8'd80;
            end
            OP_EPI1: begin
                div_num = {beta_reg, 32'b0, 32'b0};
                div_den = am1_reg;
                div_ctl.steps = 8'd96;
            end
            OP_EPI2: begin
                div_num = epi_q_reg;
                div_den = kn_reg;
                div_ctl.steps = 8'd128;
            end
            OP_INV: begin
                div_num = {1'b1, 127'b0};
                div_den = epi_floor;
                div_ctl.steps = 8'd65;
            end
            OP_EMEAN: begin
                div_num = {esum_reg, 64'b0};
                div_den = {57'b0, d_eff};
                div_ctl.steps = 8'd64;
            end
            default: begin
                div_num = {asum_reg, 64'b0};
                div_den = {57'b0, d_eff};
                div_ctl.steps = 8'd64;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (clr_reg == PW'(MAX_DIMS - 1)) state_next = S_IDLE;
            S_IDLE:      if (in_fire) state_next = S_LOAD;
            S_LOAD:      state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    case (op_reg)
                        OP_MEAN:  state_next = S_SQUARE;
                        OP_BETA:  state_next = S_BETA;
                        OP_INV:   state_next = S_SUM;
                        OP_AMEAN: state_next = S_COMMIT;
                        default:  state_next = S_DIV_START;
                    endcase
                end
            end
            S_SQUARE:    state_next = S_MUL;
            S_MUL:       if (mc_reg == 3'd4) state_next = S_DIV_START;
            S_BETA:      state_next = S_DIV_START;
            S_SUM:       state_next = last_reg ? S_DIV_START : S_COMMIT;
            S_COMMIT:    if (commit_fire) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        ram_we        = (state_reg == S_CLEAR) || commit_fire;
        ram_waddr     = (state_reg == S_CLEAR) ? clr_reg : pos_reg;
        mean_wdata    = (state_reg == S_CLEAR) ? '0 : mean_new_reg;
        ex_wdata      = (state_reg == S_CLEAR) ? '0 : ex_new_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // helper arithmetic
    always_comb begin
        delta    = {y_reg[31], y_reg} - {mu_rd[31], mu_rd};
        mean_sum = neg_reg ? ({{2{mu0_reg[31]}}, mu0_reg} - {1'b0, div_quo[32:0]})
                           : ({{2{mu0_reg[31]}}, mu0_reg} + {1'b0, div_quo[32:0]});
        am1_sum  = {33'b0, alpha_reg}
                 + ({1'b0, 64'(vcount_reg) + 64'd1} << 15);
    end

    // stream control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            pos_reg       <= '0;
            vcount_reg    <= '0;
            esum_reg      <= '0;
            asum_reg      <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_MEAN;
            mc_reg        <= '0;
        end else begin
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + PW'(1);
            end
            if (commit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_LOAD) begin
                op_reg <= OP_MEAN;
            end
            if (state_reg == S_SQUARE) begin
                mc_reg <= '0;
            end
            if (state_reg == S_MUL) begin
                mc_reg <= mc_reg + 3'd1;
                if (mc_reg == 3'd4) begin
                    op_reg <= OP_BETA;
                end
            end
            if (state_reg == S_BETA) begin
                op_reg <= (am1_sum > 65'd65536) ? OP_ALEA : OP_INV;
            end
            if (state_reg == S_DIV_WAIT && div_stat.done) begin
                case (op_reg)
                    OP_ALEA:  op_reg <= OP_EPI1;
                    OP_EPI1:  op_reg <= OP_EPI2;
                    OP_EPI2:  op_reg <= OP_INV;
                    OP_EMEAN: op_reg <= OP_AMEAN;
                    default:  ;
                endcase
            end
            if (state_reg == S_SUM) begin
                esum_reg <= sat_add(esum_reg, epi_reg);
                asum_reg <= sat_add(asum_reg, alea_reg);
                op_reg   <= OP_EMEAN;
            end
            if (commit_fire) begin
                if (last_reg) begin
                    pos_reg  <= '0;
                    esum_reg <= '0;
                    asum_reg <= '0;
                    if (vcount_reg != '1) begin
                        vcount_reg <= vcount_reg + COUNT_BITS'(1);
                    end
                end else begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
        end
    end

    // element datapath
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            y_reg    <= s_obs_value;
            last_reg <= last_now;
            k0_reg   <= 64'(kappa_reg) + (64'(vcount_reg) << 16);
        end
        case (state_reg)
            S_LOAD: begin
                mu0_reg <= mu_rd;
                ex_reg  <= ex_rd;
                neg_reg <= delta[32];
                mag_reg <= delta[32] ? 32'(-delta) : delta[31:0];
                kn_reg  <= k0_reg + 64'd65536;
            end
            S_SQUARE: begin
                sq_reg  <= mul_p;
                acc_reg <= '0;
            end
            S_MUL: begin
                pp_reg    <= mul_p;
                pp_sh_reg <= {mc_reg[0] & mc_reg[1], mc_reg[0] ^ mc_reg[1]};
                if (mc_reg != 3'd0) begin
                    case (pp_sh_reg)
                        2'd0:    acc_reg <= acc_reg + {64'b0, pp_reg};
                        2'd1:    acc_reg <= acc_reg + {32'b0, pp_reg, 32'b0};
                        default: acc_reg <= acc_reg + {pp_reg, 64'b0};
                    endcase
                end
            end
            S_BETA: begin
                beta_reg <= sat_add({16'b0, beta0_reg, 16'b0}, ex_new_reg);
                am1_reg  <= am1_sum[63:0] - 64'd65536;
                if (!(am1_sum > 65'd65536)) begin
                    alea_reg <= '1;
                    epi_reg  <= '1;
                end
            end
            S_SUM: begin
                emean_reg <= '0;
                amean_reg <= '0;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    case (op_reg)
                        OP_MEAN:  mean_new_reg <= mean_sum[31:0];
                        OP_BETA:  ex_new_reg   <= sat_add(ex_reg, sat_quo(div_quo));
                        OP_ALEA:  alea_reg     <= sat_quo(div_quo);
                        OP_EPI1:  epi_q_reg    <= div_quo;
                        OP_EPI2:  epi_reg      <= sat_quo(div_quo);
                        OP_INV:   inv_reg      <= sat_quo(div_quo);
                        OP_EMEAN: emean_reg    <= div_quo[63:0];
                        default:  amean_reg    <= div_quo[63:0];
                    endcase
                end
            end
            default: ;
        endcase
        // result word into the output register
        if (commit_fire) begin
            o_dim_reg   <= 6'(pos_reg);
            o_mean_reg  <= mean_new_reg;
            o_inv_reg   <= inv_reg;
            o_epi_reg   <= epi_reg;
            o_alea_reg  <= alea_reg;
            o_done_reg  <= last_reg;
            o_emean_reg <= emean_reg;
            o_amean_reg <= amean_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_dim_index      = o_dim_reg;
    assign m_post_mean      = o_mean_reg;
    assign m_inv_variance   = o_inv_reg;
    assign m_epistemic_var  = o_epi_reg;
    assign m_aleatoric_var  = o_alea_reg;
    assign m_vector_done    = o_done_reg;
    assign m_epistemic_mean = o_emean_reg;
    assign m_aleatoric_mean = o_amean_reg;

    // checks
    `NIG_ASSERT_IMP(a_done_in_wait, aclk, aresetn, div_stat.done, state_reg == S_DIV_WAIT)
    `NIG_ASSERT_IMP(a_accept_div_idle, aclk, aresetn, in_fire, !div_stat.busy)
    `NIG_ASSERT_NXT(a_commit_shows, aclk, aresetn, commit_fire, m_valid && state_reg == S_IDLE)
endmodule

// ----- tb/tb.sv -----
module tb;
    import nig_pkg::*;

    localparam int MAX_DIMS   = 64;
    localparam int COUNT_BITS = 24;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_obs_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_dim_index;
    logic signed [31:0] m_post_mean;
    logic [63:0]        m_inv_variance;
    logic [63:0]        m_epistemic_var;
    logic [63:0]        m_aleatoric_var;
    logic               m_vector_done;
    logic [63:0]        m_epistemic_mean;
    logic [63:0]        m_aleatoric_mean;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    nig_posterior_update_core #(
        .MAX_DIMS  (MAX_DIMS),
        .COUNT_BITS(COUNT_BITS)
    ) dut (.*);

    always #1 aclk = ~aclk;

    // directed table row kinds and typed-in checks
    typedef enum logic [1:0] {ROW_OBS, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {CHK_NONE, CHK_MEAN, CHK_SAT} typed_chk_e;

    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        typed_chk_e           chk;
        logic [31:0]          typed_mean;
    } stim_row_t;

    typedef struct {
        logic [5:0]  dim;
        logic [31:0] mean;
        logic [63:0] inv;
        logic [63:0] epi;
        logic [63:0] alea;
        logic        done;
        logic [63:0] emean;
        logic [63:0] amean;
        typed_chk_e  chk;
        logic [31:0] typed_mean;
    } posterior_t;

    // predictor state
    logic [31:0]        kappa0 = 32'd65536;
    logic [31:0]        alpha0 = 32'd131072;
    logic [31:0]        beta0  = 32'd65536;
    logic [6:0]         dims_cfg = 7'd1;
    logic signed [63:0] mean_mem [MAX_DIMS];
    logic [63:0]        excess_mem [MAX_DIMS];
    logic [63:0]        vectors_seen = '0;
    int unsigned        elem_pos = 0;
    logic [63:0]        epi_acc = '0;
    logic [63:0]        alea_acc = '0;

    posterior_t  posterior_q[$];
    int          fail_count = 0;
    int          words_seen = 0;
    int          vectors_done = 0;
    int          sat_words = 0;

    function automatic logic [63:0] clip128(input logic [127:0] v);
        return (|v[127:64]) ? '1 : v[63:0];
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [127:0] quo128(input logic [127:0] n, input logic [63:0] d);
        return (d == 0) ? '1 : n / {64'b0, d};
    endfunction

    // posterior update for one element, advancing the predictor state
    function automatic posterior_t update_posterior(input logic signed [31:0] y);
        posterior_t         r;
        int unsigned        d;
        int unsigned        pos;
        logic               last;
        logic [63:0]        k0, kn, mag, q, sq, beta, epi, alea, fl;
        logic signed [63:0] mu0, delta, am1;
        logic [127:0]       wide;
        d = (dims_cfg == 0) ? 1 : (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
        pos = (elem_pos < MAX_DIMS) ? elem_pos : MAX_DIMS - 1;
        last = (pos + 1 >= d);
        k0 = {32'b0, kappa0} + (vectors_seen << 16);
        kn = k0 + 64'd65536;
        mu0 = mean_mem[pos];
        delta = 64'(y) - mu0;
        mag = (delta < 0) ? 64'(-delta) : 64'(delta);
        // mean moves toward the sample by delta / kappa_n
        q = (mag << 16) / kn;
        mean_mem[pos] = (delta < 0) ? mu0 - $signed(q) : mu0 + $signed(q);
        // beta excess grows by k0 * delta^2 / (2 kappa_n)
        sq = mag * mag;
        wide = {64'b0, sq} * {64'b0, k0};
        excess_mem[pos] = add_clip(excess_mem[pos], clip128(quo128(wide, kn << 1)));
        beta = add_clip({32'b0, beta0} << 16, excess_mem[pos]);
        am1 = $signed({32'b0, alpha0}) + $signed((vectors_seen + 64'd1) * 64'd32768)
            - 64'sd65536;
        if (am1 <= 0) begin
            alea = '1;
            epi = '1;
        end else begin
            alea = clip128(quo128({64'b0, beta} << 16, am1));
            epi = clip128(quo128(quo128({64'b0, beta} << 32, am1), kn));
        end
        fl = (epi < 4) ? 64'd4 : epi;
        r.inv = clip128(quo128(128'd1 << 64, fl));
        epi_acc = add_clip(epi_acc, epi);
        alea_acc = add_clip(alea_acc, alea);
        r.dim = pos[5:0];
        r.mean = mean_mem[pos][31:0];
        r.epi = epi;
        r.alea = alea;
        r.done = last;
        r.emean = '0;
        r.amean = '0;
        r.chk = CHK_NONE;
        r.typed_mean = '0;
        if (last) begin
            r.emean = epi_acc / d;
            r.amean = alea_acc / d;
            epi_acc = '0;
            alea_acc = '0;
            elem_pos = 0;
            if (vectors_seen < (64'd1 << COUNT_BITS) - 1) vectors_seen++;
        end else begin
            elem_pos = pos + 1;
        end
        return r;
    endfunction

    // send one observation word, predict on acceptance
    task automatic send_obs(input logic [31:0] v, input typed_chk_e chk,
                            input logic [31:0] tmean);
        posterior_t p;
        s_valid <= 1'b1;
        s_obs_value <= v;
        do @(posedge aclk); while (!s_ready);
        p = update_posterior(v);
        p.chk = chk;
        p.typed_mean = tmean;
        posterior_q.push_back(p);
    endtask

    task automatic sender_gap();
        int g;
        int pick;
        pick = $urandom_range(0, 99);
        g = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 6) : $urandom_range(20, 200);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // drain outstanding results, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        s_valid <= 1'b0;
        while (posterior_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PRIOR_KAPPA: kappa0 = v;
            REG_PRIOR_ALPHA: alpha0 = v;
            REG_PRIOR_BETA:  beta0 = v;
            REG_DIMS_IN_USE: dims_cfg = v[6:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_obs();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom_range(0, 20) << 16;
            4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_prior(input logic [31:0] lo);
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return lo;
            1: return 32'hffffffff;
            2, 3, 4: return $urandom_range(1 << 16, 8 << 16) + lo;
            default: return ($urandom | 32'h1) | lo;
        endcase
    endfunction

    // directed table: register writes and observation words in order
    stim_row_t directed_rows[] = '{
        '{ROW_OBS, '0, 32'h0, CHK_MEAN, 32'h0},
        // alpha not above one saturates both variances, while few vectors are seen
        '{ROW_CFG, REG_PRIOR_ALPHA, 32'd0, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00080000, CHK_SAT, '0},
        '{ROW_CFG, REG_PRIOR_ALPHA, 32'd131072, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h7fffffff, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h80000000, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00000001, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'hffffffff, CHK_NONE, '0},
        '{ROW_CFG, REG_DIMS_IN_USE, 32'd3, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00010000, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'hfffe0000, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00030000, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00050000, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00060000, CHK_NONE, '0},
        // shrink the vector under the current position
        '{ROW_CFG, REG_DIMS_IN_USE, 32'd1, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00070000, CHK_NONE, '0},
        // zero dimensions act as one, oversize acts as the maximum
        '{ROW_CFG, REG_DIMS_IN_USE, 32'd0, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00020000, CHK_NONE, '0},
        '{ROW_CFG, REG_DIMS_IN_USE, 32'd127, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00040000, CHK_NONE, '0},
        // tiny variance hits the floor
        '{ROW_CFG, REG_PRIOR_KAPPA, 32'hffffffff, CHK_NONE, '0},
        '{ROW_CFG, REG_PRIOR_ALPHA, 32'hffffffff, CHK_NONE, '0},
        '{ROW_CFG, REG_PRIOR_BETA, 32'd1, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h00000000, CHK_NONE, '0},
        '{ROW_CFG, REG_PRIOR_KAPPA, 32'd1, CHK_NONE, '0},
        '{ROW_CFG, REG_PRIOR_BETA, 32'hffffffff, CHK_NONE, '0},
        '{ROW_OBS, '0, 32'h7fffffff, CHK_NONE, '0}
    };

    // result checker with random backpressure
    int stall_left = 0;
    always @(posedge aclk) begin
        posterior_t e;
        int pick;
        if (m_valid && m_ready) begin
            words_seen++;
            if (m_vector_done) vectors_done++;
            if (posterior_q.size() == 0) begin
                $error("result word with nothing expected, dim %0d", m_dim_index);
                fail_count++;
            end else begin
                e = posterior_q.pop_front();
                if (e.epi == '1) sat_words++;
                if (m_dim_index !== e.dim) begin
                    $error("dim_index exp %0d got %0d", e.dim, m_dim_index);
                    fail_count++;
                end
                if (m_post_mean !== e.mean) begin
                    $error("post_mean exp %h got %h", e.mean, m_post_mean);
                    fail_count++;
                end
                if (m_inv_variance !== e.inv) begin
                    $error("inv_variance exp %h got %h", e.inv, m_inv_variance);
                    fail_count++;
                end
                if (m_epistemic_var !== e.epi) begin
                    $error("epistemic_var exp %h got %h", e.epi, m_epistemic_var);
                    fail_count++;
                end
                if (m_aleatoric_var !== e.alea) begin
                    $error("aleatoric_var exp %h got %h", e.alea, m_aleatoric_var);
                    fail_count++;
                end
                if (m_vector_done !== e.done) begin
                    $error("vector_done exp %b got %b", e.done, m_vector_done);
                    fail_count++;
                end
                if (m_epistemic_mean !== e.emean) begin
                    $error("epistemic_mean exp %h got %h", e.emean, m_epistemic_mean);
                    fail_count++;
                end
                if (m_aleatoric_mean !== e.amean) begin
                    $error("aleatoric_mean exp %h got %h", e.amean, m_aleatoric_mean);
                    fail_count++;
                end
                // values that can be read straight off the spec
                if (e.chk == CHK_MEAN && m_post_mean !== e.typed_mean) begin
                    $error("post_mean exp %h got %h", e.typed_mean, m_post_mean);
                    fail_count++;
                end
                if (e.chk == CHK_SAT && (m_epistemic_var !== '1 || m_aleatoric_var !== '1
                        || m_inv_variance !== 64'd1)) begin
                    $error("saturated variances exp %h/%h/1 got %h/%h/%h", 64'hffffffffffffffff,
                           64'hffffffffffffffff, m_epistemic_var, m_aleatoric_var,
                           m_inv_variance);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                stall_left <= $urandom_range(1, 6);
                m_ready <= 1'b0;
            end else if (pick < 10) begin
                stall_left <= $urandom_range(50, 300);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin
        int n_items;
        int phase;
        int pick;
        logic [31:0] dsel;
        for (int i = 0; i < MAX_DIMS; i++) begin
            mean_mem[i] = '0;
            excess_mem[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_obs(directed_rows[i].val, directed_rows[i].chk,
                         directed_rows[i].typed_mean);
                sender_gap();
            end
        end

        // random phases, each under a fresh prior setting
        n_items = 0;
        phase = 0;
        while (n_items < 1500) begin
            pick = $urandom_range(0, 19);
            if (phase == 0) write_reg(REG_PRIOR_ALPHA, 32'd65537);
            else if (pick == 0) write_reg(REG_PRIOR_ALPHA, $urandom_range(0, 65536));
            else write_reg(REG_PRIOR_ALPHA, rand_prior(32'd65537));
            write_reg(REG_PRIOR_KAPPA, (phase == 0) ? 32'd1 : rand_prior(32'd1));
            write_reg(REG_PRIOR_BETA, (phase == 1) ? 32'hffffffff : rand_prior(32'd1));
            pick = $urandom_range(0, 19);
            dsel = (pick == 0) ? 32'd64 : (pick == 1) ? 32'd0 :
                   (pick == 2) ? $urandom_range(65, 127) : $urandom_range(1, 8);
            write_reg(REG_DIMS_IN_USE, dsel);
            for (int k = 0; k < 150 && n_items < 1500; k++) begin
                send_obs(rand_obs(), CHK_NONE, '0);
                n_items++;
                sender_gap();
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (posterior_q.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        $display("covered %0d result words, %0d vectors, %0d prior settings",
                 words_seen, vectors_done, phase);
        $display("saturated epistemic words: %0d", sat_words);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- nig_posterior_update_core.f -----
+incdir+hw/rtl
hw/rtl/nig_pkg.sv
hw/rtl/nig_ram.sv
hw/rtl/nig_div.sv
hw/rtl/nig_posterior_update_core.sv
tb/tb.sv
